>>> sv/dcsm_pkg.sv
package dcsm_pkg;

    localparam int FifoWordsDefault   = 8;
    localparam int LockCountDefault   = 32;
    localparam int CoreCountDefault   = 2;
    localparam int InterpWordsDefault = 16;

    localparam logic [11:0] OFF_CPUID      = 12'h000;
    localparam logic [11:0] OFF_GPIO_IN    = 12'h004;
    localparam logic [11:0] OFF_OUT        = 12'h010;
    localparam logic [11:0] OFF_OUT_SET    = 12'h014;
    localparam logic [11:0] OFF_OUT_CLR    = 12'h018;
    localparam logic [11:0] OFF_OUT_XOR    = 12'h01C;
    localparam logic [11:0] OFF_OE         = 12'h020;
    localparam logic [11:0] OFF_OE_SET     = 12'h024;
    localparam logic [11:0] OFF_OE_CLR     = 12'h028;
    localparam logic [11:0] OFF_OE_XOR     = 12'h02C;
    localparam logic [11:0] OFF_FIFO_ST    = 12'h050;
    localparam logic [11:0] OFF_FIFO_WR    = 12'h054;
    localparam logic [11:0] OFF_FIFO_RD    = 12'h058;
    localparam logic [11:0] OFF_LOCK_ST    = 12'h05C;
    localparam logic [11:0] OFF_UDIVIDEND  = 12'h060;
    localparam logic [11:0] OFF_UDIVISOR   = 12'h064;
    localparam logic [11:0] OFF_SDIVIDEND  = 12'h068;
    localparam logic [11:0] OFF_SDIVISOR   = 12'h06C;
    localparam logic [11:0] OFF_QUOTIENT   = 12'h070;
    localparam logic [11:0] OFF_REMAINDER  = 12'h074;
    localparam logic [11:0] OFF_CSR        = 12'h078;
    localparam logic [11:0] INTERP0_BASE   = 12'h080;
    localparam logic [11:0] INTERP1_BASE   = 12'h0C0;
    localparam logic [11:0] LOCK_BASE      = 12'h100;
    localparam logic [11:0] LOCK_END       = 12'h180;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        operation;
        logic        core;
        logic [11:0] offset;
        logic [31:0] write_data;
        logic [31:0] gpio_in_level;
        logic        core1_running;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_core0;
        logic        irq_core1;
        logic        event_core0;
        logic        event_core1;
        logic        launch_valid;
        logic [31:0] launch_vector;
        logic [31:0] launch_stack;
        logic [31:0] launch_pc;
        logic [31:0] gpio_out_level;
        logic [31:0] gpio_out_enable;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_needed;
        logic div_last;
    } ctl_sts_t;

endpackage

>>> sv/dcsm_if.sv
interface dcsm_req_if;
    import dcsm_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dcsm_rsp_if;
    import dcsm_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/dual_core_sio_mailbox_lock_divider.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | operation, core, offset, write_data, gpio_in_level, core1_running
// rsp     | out | valid/ready | read_data, irq levels, event/launch flags, launch and gpio registers
//
// an access passes through the idle, exec and result states; a divisor write adds the div
// and fin states, in the radix-4 divider that retires two quotient bits per cycle.
// one access at a time: ready is high only while no access is held.
// a stalled result holds until taken. reset at once clears all but memories, capture and divider.
module dual_core_sio_mailbox_lock_divider #(
    parameter int FifoWords = dcsm_pkg::FifoWordsDefault,
    parameter int LockCount = dcsm_pkg::LockCountDefault
) (
    input  logic   clk,
    input  logic   rst_n,
    dcsm_req_if.sink   req,
    dcsm_rsp_if.source rsp
);
    import dcsm_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    dcsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dcsm_datapath #(
        .FifoWords (FifoWords),
        .LockCount (LockCount)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp.data)
    );

endmodule

>>> sv/dcsm_ctrl.sv
module dcsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dcsm_pkg::ctl_sts_t  sts,
    output dcsm_pkg::ctl_cmd_t  cmd
);
    import dcsm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.div_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.div_finish = 1'b1;
                cmd.exec = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dcsm_datapath.sv
module dcsm_datapath #(
    parameter int FifoWords = dcsm_pkg::FifoWordsDefault,
    parameter int LockCount = dcsm_pkg::LockCountDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dcsm_pkg::req_t     req,
    input  dcsm_pkg::ctl_cmd_t cmd,
    output dcsm_pkg::ctl_sts_t sts,
    output dcsm_pkg::rsp_t     rsp
);
    import dcsm_pkg::*;

    localparam int PtrW = (FifoWords > 1) ? $clog2(FifoWords) : 1;
    localparam int CntW = $clog2(FifoWords + 1);
    localparam int SumW = CntW + 1;
    // radix-4 long division, two quotient bits per cycle
    localparam int DivSteps = 16;

    req_t r_reg;

    logic [31:0] mbox_mem [2][FifoWords];
    logic [PtrW-1:0] head_reg [2];
    logic [CntW-1:0] count_reg [2];
    logic [1:0] wfull_reg, rempty_reg;
    logic [31:0] lock_reg;
    logic [31:0] dvd_reg [2];
    logic [31:0] dvs_reg [2];
    logic [31:0] quo_reg [2];
    logic [31:0] rem_reg [2];
    logic [1:0] sgn_reg, dirty_reg;
    logic [31:0] interp_mem [64];
    logic [63:0] interp_vld_reg;
    logic [2:0] lstep_reg;
    logic [31:0] lvtor_reg, lsp_reg, lentry_reg, gout_reg, goe_reg;
    logic [31:0] rd_reg;
    logic [1:0] ev_reg;
    logic lv_reg;
    logic [31:0] pop_rd_reg, interp_rd_reg;

    // divider
    logic [31:0] d_q_reg, d_r_reg, d_b_reg;
    logic [3:0] d_cnt_reg;
    logic d_an_reg, d_bn_reg, d_zero_reg, d_sgn_reg;

    logic c, o, wr;
    logic [11:0] off;
    logic [31:0] val;

    assign c   = r_reg.core;
    assign o   = ~r_reg.core;
    assign wr  = r_reg.operation;
    assign off = r_reg.offset;
    assign val = r_reg.write_data;

    assign sts.div_needed = wr && (off == OFF_UDIVISOR || off == OFF_SDIVISOR);
    assign sts.div_last   = (d_cnt_reg == 4'(DivSteps - 1));

    logic in_lock, in_interp, lock_ok;
    logic [4:0] lock_n;
    logic [5:0] interp_idx;
    logic launch_path;
    logic push_en;
    logic push_c;
    logic [31:0] push_val;
    logic [SumW-1:0] tail_sum;
    logic [PtrW-1:0] tail_ptr;

    assign in_lock    = off >= LOCK_BASE && off < LOCK_END;
    assign in_interp  = off >= INTERP0_BASE && off < LOCK_BASE;
    assign lock_n     = off[6:2];
    assign lock_ok    = in_lock && (32'(lock_n) < 32'(LockCount));
    assign interp_idx = {c, off[6], off[5:2]};
    assign launch_path = !c && !r_reg.core1_running;

    // tail slot, wrapped by one compare and subtract
    assign tail_sum = SumW'(head_reg[push_c]) + SumW'(count_reg[push_c]);
    assign tail_ptr = (tail_sum >= SumW'(FifoWords)) ? PtrW'(tail_sum - SumW'(FifoWords))
                                                     : PtrW'(tail_sum);

    // one radix-2 step, applied twice per cycle
    function automatic logic [63:0] dstep(logic [31:0] rr, logic [31:0] qq, logic [31:0] bb);
        logic [32:0] t;
        logic [32:0] sh;
        sh = {rr, qq[31]};
        t  = sh - {1'b0, bb};
        if (!t[32])
            dstep = {t[31:0], qq[30:0], 1'b1};
        else
            dstep = {sh[31:0], qq[30:0], 1'b0};
    endfunction

    logic [63:0] s1, s2;
    assign s1 = dstep(d_r_reg, d_q_reg, d_b_reg);
    assign s2 = dstep(s1[63:32], s1[31:0], d_b_reg);

    logic [31:0] fin_q, fin_r;
    always_comb
    begin
        if (d_zero_reg)
        begin
            fin_q = (d_sgn_reg && d_an_reg) ? 32'd1 : ALL_ONES;
            fin_r = dvd_reg[c];
        end
        else
        begin
            fin_q = (d_sgn_reg && (d_an_reg != d_bn_reg)) ? (32'd0 - d_q_reg) : d_q_reg;
            fin_r = (d_sgn_reg && d_an_reg) ? (32'd0 - d_r_reg) : d_r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            r_reg <= req;
            pop_rd_reg <= mbox_mem[req.core][head_reg[req.core]];
            interp_rd_reg <= interp_mem[{req.core, req.offset[6], req.offset[5:2]}];
        end
        if (cmd.div_start)
        begin
            d_sgn_reg  <= (off == OFF_SDIVISOR);
            d_an_reg   <= (off == OFF_SDIVISOR) && dvd_reg[c][31];
            d_bn_reg   <= (off == OFF_SDIVISOR) && val[31];
            d_zero_reg <= (val == 32'd0);
            d_q_reg    <= ((off == OFF_SDIVISOR) && dvd_reg[c][31]) ? 32'd0 - dvd_reg[c]
                                                                   : dvd_reg[c];
            d_b_reg    <= ((off == OFF_SDIVISOR) && val[31]) ? 32'd0 - val : val;
            d_r_reg    <= '0;
            d_cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            d_r_reg   <= s2[63:32];
            d_q_reg   <= s2[31:0];
            d_cnt_reg <= d_cnt_reg + 4'd1;
        end
        if (cmd.exec && push_en)
        begin
            mbox_mem[push_c][tail_ptr] <= push_val;
        end
        if (cmd.exec && wr && in_interp)
        begin
            interp_mem[interp_idx] <= val;
        end
    end

    logic [31:0] pop_word, interp_word;
    assign pop_word    = pop_rd_reg;
    assign interp_word = interp_vld_reg[interp_idx] ? interp_rd_reg : 32'd0;

    always_comb
    begin
        push_en  = 1'b0;
        push_c   = o;
        push_val = val;
        if (wr && off == OFF_FIFO_WR)
        begin
            push_c  = launch_path ? 1'b0 : o;
            push_en = 32'(count_reg[push_c]) < FifoWords;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '{default: '0};
            count_reg  <= '{default: '0};
            wfull_reg  <= '0;
            rempty_reg <= '0;
            lock_reg   <= '0;
            dvd_reg    <= '{default: '0};
            dvs_reg    <= '{default: '0};
            quo_reg    <= '{default: '0};
            rem_reg    <= '{default: '0};
            sgn_reg    <= '0;
            dirty_reg  <= '0;
            interp_vld_reg <= '0;
            lstep_reg  <= '0;
            lvtor_reg  <= '0;
            lsp_reg    <= '0;
            lentry_reg <= '0;
            gout_reg   <= '0;
            goe_reg    <= '0;
            rd_reg     <= '0;
            ev_reg     <= '0;
            lv_reg     <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rd_reg <= '0;
            ev_reg <= '0;
            lv_reg <= 1'b0;
            if (!wr)
            begin
                priority if (off == OFF_CPUID)
                    rd_reg <= {31'd0, c};
                else if (off == OFF_GPIO_IN)
                    rd_reg <= r_reg.gpio_in_level;
                else if (off == OFF_OUT || off == OFF_OUT_SET || off == OFF_OUT_CLR
                         || off == OFF_OUT_XOR)
                    rd_reg <= gout_reg;
                else if (off == OFF_OE || off == OFF_OE_SET || off == OFF_OE_CLR
                         || off == OFF_OE_XOR)
                    rd_reg <= goe_reg;
                else if (off == OFF_FIFO_ST)
                    rd_reg <= {28'd0, rempty_reg[c], wfull_reg[c],
                               32'(count_reg[o]) < FifoWords, count_reg[c] != '0};
                else if (off == OFF_FIFO_RD)
                begin
                    if (count_reg[c] == '0)
                        rempty_reg[c] <= 1'b1;
                    else
                    begin
                        rd_reg <= pop_word;
                        head_reg[c] <= (32'(head_reg[c]) == FifoWords - 1) ? '0
                                                                           : head_reg[c] + 1'b1;
                        count_reg[c] <= count_reg[c] - 1'b1;
                    end
                end
                else if (off == OFF_LOCK_ST)
                    rd_reg <= lock_reg;
                else if (off == OFF_UDIVIDEND || off == OFF_SDIVIDEND)
                    rd_reg <= dvd_reg[c];
                else if (off == OFF_UDIVISOR || off == OFF_SDIVISOR)
                    rd_reg <= dvs_reg[c];
                else if (off == OFF_QUOTIENT)
                begin
                    rd_reg <= quo_reg[c];
                    dirty_reg[c] <= 1'b0;
                end
                else if (off == OFF_REMAINDER)
                    rd_reg <= rem_reg[c];
                else if (off == OFF_CSR)
                    rd_reg <= {30'd0, dirty_reg[c], 1'b1};
                else if (lock_ok)
                begin
                    if (!lock_reg[lock_n])
                    begin
                        lock_reg[lock_n] <= 1'b1;
                        rd_reg <= (lock_n == 5'd0) ? 32'd1 : {27'd0, lock_n};
                    end
                end
                else if (in_interp)
                    rd_reg <= interp_word;
                else
                begin
                    // unlisted offsets read zero
                end
            end
            else
            begin
                priority if (off == OFF_OUT)     gout_reg <= val;
                else if (off == OFF_OUT_SET)     gout_reg <= gout_reg | val;
                else if (off == OFF_OUT_CLR)     gout_reg <= gout_reg & ~val;
                else if (off == OFF_OUT_XOR)     gout_reg <= gout_reg ^ val;
                else if (off == OFF_OE)          goe_reg <= val;
                else if (off == OFF_OE_SET)      goe_reg <= goe_reg | val;
                else if (off == OFF_OE_CLR)      goe_reg <= goe_reg & ~val;
                else if (off == OFF_OE_XOR)      goe_reg <= goe_reg ^ val;
                else if (off == OFF_FIFO_ST)
                begin
                    if (val[2]) wfull_reg[c] <= 1'b0;
                    if (val[3]) rempty_reg[c] <= 1'b0;
                end
                else if (off == OFF_FIFO_WR)
                begin
                    if (push_en)
                        count_reg[push_c] <= count_reg[push_c] + 1'b1;
                    else
                        wfull_reg[push_c] <= 1'b1;
                    ev_reg[push_c] <= 1'b1;
                    if (launch_path)
                    begin
                        unique case (lstep_reg)
                            3'd0: lstep_reg <= (val == 32'd0) ? 3'd1 : 3'd0;
                            3'd1: lstep_reg <= (val == 32'd0) ? 3'd2 : 3'd0;
                            3'd2: lstep_reg <= (val == 32'd1) ? 3'd3
                                             : ((val == 32'd0) ? 3'd1 : 3'd0);
                            3'd3:
                            begin
                                lvtor_reg <= val;
                                lstep_reg <= 3'd4;
                            end
                            3'd4:
                            begin
                                lsp_reg <= val;
                                lstep_reg <= 3'd5;
                            end
                            3'd5:
                            begin
                                lentry_reg <= val;
                                lstep_reg <= 3'd6;
                                lv_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                else if (off == OFF_UDIVIDEND || off == OFF_SDIVIDEND)
                begin
                    dvd_reg[c] <= val;
                    sgn_reg[c] <= (off == OFF_SDIVIDEND);
                end
                else if (off == OFF_UDIVISOR || off == OFF_SDIVISOR)
                begin
                    dvs_reg[c] <= val;
                    sgn_reg[c] <= (off == OFF_SDIVISOR);
                    if (cmd.div_finish)
                    begin
                        quo_reg[c] <= fin_q;
                        rem_reg[c] <= fin_r;
                        dirty_reg[c] <= 1'b1;
                    end
                end
                else if (off == OFF_QUOTIENT)
                begin
                    quo_reg[c] <= val;
                    dirty_reg[c] <= 1'b1;
                end
                else if (off == OFF_REMAINDER)
                begin
                    rem_reg[c] <= val;
                    dirty_reg[c] <= 1'b1;
                end
                else if (lock_ok)
                begin
                    lock_reg[lock_n] <= 1'b0;
                    ev_reg[o] <= 1'b1;
                end
                else if (in_interp)
                    interp_vld_reg[interp_idx] <= 1'b1;
                else
                begin
                    // writes elsewhere are ignored
                end
            end
        end
    end

    always_comb
    begin
        rsp.read_data       = rd_reg;
        rsp.irq_core0       = (count_reg[0] != '0) || wfull_reg[0] || rempty_reg[0];
        rsp.irq_core1       = (count_reg[1] != '0) || wfull_reg[1] || rempty_reg[1];
        rsp.event_core0     = ev_reg[0];
        rsp.event_core1     = ev_reg[1];
        rsp.launch_valid    = lv_reg;
        rsp.launch_vector   = lvtor_reg;
        rsp.launch_stack    = lsp_reg;
        rsp.launch_pc       = lentry_reg;
        rsp.gpio_out_level  = gout_reg;
        rsp.gpio_out_enable = goe_reg;
    end

endmodule

>>> sv/dcsm_checker.sv
module dcsm_props (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_launch_valid,
    input logic [31:0] rsp_gpio_out_level
);
    // no new request while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("ready while result pending");

    // an accepted request passes through the exec state before its result is valid
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");

    a_gpio: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp_gpio_out_level)
                                       && $stable(rsp_launch_valid))
        else $error("result changed while stalled");
endmodule

bind dual_core_sio_mailbox_lock_divider dcsm_props u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_launch_valid   (rsp.data.launch_valid),
    .rsp_gpio_out_level (rsp.data.gpio_out_level)
);
